/* hw/rtl/prid_pkg.sv */
// prid_pkg: shared constants, code values and control/status structs
// for the planar run-length image decoder; no dependencies
`default_nettype none
package prid_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int HIST_DEPTH  = 1024;
  localparam int HIST_AW     = 10;
  localparam int POS_W       = 19;

  // command byte codes
  localparam logic [7:0] CODE_FILL_EXPL = 8'h00;
  localparam logic [7:0] CODE_COPY_P2   = 8'h0E;
  localparam logic [7:0] CODE_COPY_P01  = 8'h0F;
  localparam logic [7:0] CODE_LIT_MIN   = 8'h10;
  localparam logic [7:0] CODE_REP_MAX   = 8'h07;
  localparam logic [7:0] CODE_BACK_BIAS = 8'h06;
  localparam logic [7:0] LEN_MASK       = 8'h7F;

  // parser phases
  localparam logic [1:0] PH_CMD = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;   // input beat taken
    logic rd;       // issue history read
    logic latch;    // latch fill value from history
    logic wr;       // produce one decoded byte
    logic push;     // move held beat into output register
  } prid_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic go;         // accepted byte starts a run
    logic fetch;      // run value comes from history
    logic dec_copy;   // accepted byte starts a copy run
    logic run_copy;   // current run is a copy
    logic beat;       // byte being written closes a beat
    logic out_free;   // output register can take a beat
    logic last_byte;  // byte being written is the last of the run
  } prid_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/planar_rle_image_decoder.sv */
// planar_rle_image_decoder: top level, joins controller and datapath
// depends on prid_pkg, prid_ctrl, prid_dp
//
// channel  dir  beat contents
// in_      in   tdata[7:0] code_byte; tuser[0] image_start
// out_     out  tdata[31:0] pixel_bytes, [34:32] byte_count; tlast run_last;
//               tuser[0] image_done
// cfg_     in   addr 0 columns, addr 1 rows; write when cfg_we high
//
// a literal or fill writes one decoded byte per cycle while the output register
// is free, a copy does a registered history read, then a write, per byte, and a
// fill from history first reads and then latches its value
// rst_n clears the parser, position and output register synchronously
// a completed beat waits in the datapath while the output register is stalled
`default_nettype none
module planar_rle_image_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [9:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // code_byte
  input  wire logic [0:0]  in_tuser,   // image_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // pixel_bytes, byte_count, zero pad
  output logic             out_tlast,
  output logic [0:0]       out_tuser   // image_done
);
  import prid_pkg::*;

  prid_cmd_t   cmd;
  prid_stat_t  st;
  logic [31:0] pix;
  logic [2:0]  cnt;
  logic        done;

  prid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  prid_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_start   (in_tuser[0]),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pixels (pix),
    .out_count  (cnt),
    .out_last   (out_tlast),
    .out_done   (done),
    .cmd        (cmd),
    .st         (st)
  );

  assign out_tdata = {5'd0, cnt, pix};
  assign out_tuser = done;

endmodule
`default_nettype wire

/* hw/rtl/prid_ctrl.sv */
// prid_ctrl: sequencing state machine of the decoder
// depends on prid_pkg
`default_nettype none
module prid_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire prid_pkg::prid_stat_t st,
  output prid_pkg::prid_cmd_t       cmd
);
  import prid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FRD   = 6'b000010,
    S_FLAT  = 6'b000100,
    S_RD    = 6'b001000,
    S_WR    = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (st.go) begin
            if (st.fetch) state_nxt = S_FRD;
            else if (st.dec_copy) state_nxt = S_RD;
            else state_nxt = S_WR;
          end
        end
      end
      S_FRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FLAT;
      end
      S_FLAT: begin
        cmd.latch = 1'b1;
        state_nxt = S_WR;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (st.beat && !st.out_free) state_nxt = S_PUSH;
        else if (st.last_byte) state_nxt = S_IDLE;
        else if (st.run_copy) state_nxt = S_RD;
        else state_nxt = S_WR;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (st.out_free) begin
          if (st.last_byte) state_nxt = S_IDLE;
          else if (st.run_copy) state_nxt = S_RD;
          else state_nxt = S_WR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/prid_dp.sv */
// prid_dp: parser, position counters, history memory and output register
// depends on prid_pkg
`default_nettype none
module prid_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_addr,
  input  wire logic [9:0]          cfg_wdata,
  input  wire logic                in_start,
  input  wire logic [7:0]          in_byte,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [31:0]              out_pixels,
  output logic [2:0]               out_count,
  output logic                     out_last,
  output logic                     out_done,
  input  wire prid_pkg::prid_cmd_t cmd,
  output prid_pkg::prid_stat_t     st
);
  import prid_pkg::*;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_LIT  = 2'd1;
  localparam logic [1:0] M_FILL = 2'd2;
  localparam logic [1:0] M_COPY = 2'd3;

  // configuration
  logic [7:0] columns_r;
  logic [9:0] rows_r;

  // decode state
  logic [POS_W-1:0]   pos_r, total_r;
  logic [6:0]         col_r;
  logic [1:0]         plane_r, phase_r;
  logic [7:0]         hcmd_r, hlen_r;
  logic               copy_r, dok_r, ok_r;
  logic [HIST_AW-1:0] dist_r;
  logic [6:0]         left_r;
  logic [7:0]         value_r;
  logic [31:0]        acc_r;
  logic [2:0]         nb_r;
  logic               pend_last_r, pend_done_r;

  // output register
  logic        ovalid_r, olast_r, odone_r;
  logic [31:0] opix_r;
  logic [2:0]  ocnt_r;

  // history memory
  logic [7:0]         hist_mem [HIST_DEPTH];
  logic [7:0]         rdata_r;
  logic [HIST_AW-1:0] raddr;

  // decode of the accepted byte
  logic [POS_W-1:0] pos_eff, total, rem;
  logic [1:0]       plane_eff, phase_eff, d_phase, d_mode;
  logic [7:0]       c_eff, d_hcmd, d_hlen, d_value, d_len8;
  logic [17:0]      prod;
  logic             active, d_fetch, d_dok;
  logic [2:0]       k;
  logic [10:0]      d_dist;
  logic [6:0]       d_len, len_cl;

  always_comb begin
    pos_eff   = in_start ? '0 : pos_r;
    plane_eff = in_start ? 2'd0 : plane_r;
    phase_eff = in_start ? PH_CMD : phase_r;
    c_eff     = (columns_r > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : columns_r;
    prod      = c_eff * rows_r;
    total     = {prod[POS_W-3:0], 2'b00};
    active    = pos_eff < total;
    d_phase   = PH_CMD;
    d_mode    = M_NONE;
    d_hcmd    = hcmd_r;
    d_hlen    = hlen_r;
    d_value   = in_byte;
    d_len8    = 8'd0;
    d_fetch   = 1'b0;
    d_dok     = 1'b1;
    d_dist    = {c_eff, 3'b000} - 11'd1;
    k         = 3'd0;
    case (phase_eff)
      PH_LEN: begin
        d_hlen = in_byte;
        d_len8 = in_byte & LEN_MASK;
        if (hcmd_r == CODE_FILL_EXPL) begin
          if (in_byte[7]) begin
            d_mode  = M_FILL;
            d_fetch = 1'b1;
          end else begin
            d_phase = PH_VAL;
          end
        end else begin
          d_mode = M_COPY;
          if (hcmd_r == CODE_COPY_P2) k = {1'b0, plane_eff} - 3'd2;
          else if (in_byte[7]) k = {1'b0, plane_eff} - 3'd1;
          else k = {1'b0, plane_eff};
          d_dok  = !k[2] && (k != 3'd0);
          d_dist = {3'd0, c_eff} * {9'd0, k[1:0]};
        end
      end
      PH_VAL: begin
        d_mode = M_FILL;
        d_len8 = (hcmd_r == CODE_FILL_EXPL) ? (hlen_r & LEN_MASK) : {5'd0, hcmd_r[2:0]};
      end
      default: begin
        if (in_byte >= CODE_LIT_MIN) begin
          d_mode = M_LIT;
          d_len8 = 8'd1;
        end else if (in_byte != CODE_FILL_EXPL && in_byte <= CODE_REP_MAX) begin
          d_hcmd  = in_byte;
          d_phase = PH_VAL;
        end else if (in_byte == CODE_FILL_EXPL || in_byte == CODE_COPY_P2
                     || in_byte == CODE_COPY_P01) begin
          d_hcmd  = in_byte;
          d_phase = PH_LEN;
        end else begin
          d_mode  = M_FILL;
          d_len8  = in_byte - CODE_BACK_BIAS;
          d_fetch = 1'b1;
        end
      end
    endcase
    d_len  = d_len8[6:0];
    rem    = total - pos_eff;
    len_cl = ({12'd0, d_len} > rem) ? rem[6:0] : d_len;
  end

  // per-byte values
  logic [7:0]       v;
  logic [31:0]      acc_new;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       col_inc;
  logic             beat, out_free, last_byte, done_new, load_out;

  always_comb begin
    v        = copy_r ? (ok_r ? rdata_r : 8'd0) : value_r;
    acc_new  = acc_r;
    acc_new[nb_r[1:0]*8 +: 8] = v;
    pos_inc  = pos_r + 1'b1;
    col_inc  = {1'b0, col_r} + 8'd1;
    last_byte = (left_r == 7'd1);
    beat     = last_byte || (nb_r == 3'd3);
    done_new = (pos_inc == total_r);
    out_free = !ovalid_r || out_tready;
    load_out = (cmd.wr && beat && out_free) || (cmd.push && out_free);
    raddr    = pos_r[HIST_AW-1:0] - dist_r;
  end

  always_comb begin
    st.go        = active && (d_mode != M_NONE) && (len_cl != 7'd0);
    st.fetch     = d_fetch;
    st.dec_copy  = (d_mode == M_COPY);
    st.run_copy  = copy_r;
    st.beat      = beat;
    st.out_free  = out_free;
    st.last_byte = cmd.push ? pend_last_r : last_byte;
  end

  // history memory port
  always_ff @(posedge clk) begin
    if (cmd.wr) hist_mem[pos_r[HIST_AW-1:0]] <= v;
    rdata_r <= hist_mem[raddr];
  end

  // configuration and parser control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 8'd80;
      rows_r    <= 10'd400;
      pos_r     <= '0;
      col_r     <= '0;
      plane_r   <= '0;
      phase_r   <= PH_CMD;
      hcmd_r    <= '0;
      hlen_r    <= '0;
      left_r    <= '0;
      nb_r      <= '0;
      acc_r     <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr) rows_r <= cfg_wdata;
        else columns_r <= cfg_wdata[7:0];
      end
      if (load_out) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (cmd.accept) begin
        pos_r <= pos_eff;
        if (in_start) begin
          col_r   <= '0;
          plane_r <= '0;
        end
        phase_r <= active ? d_phase : phase_eff;
        if (active) begin
          hcmd_r <= d_hcmd;
          hlen_r <= d_hlen;
          left_r <= len_cl;
        end
        acc_r <= '0;
        nb_r  <= '0;
      end
      if (cmd.wr) begin
        pos_r  <= pos_inc;
        left_r <= left_r - 7'd1;
        if (col_inc >= c_eff) begin
          col_r   <= '0;
          plane_r <= plane_r + 2'd1;
        end else begin
          col_r <= col_inc[6:0];
        end
        if (beat && out_free) begin
          acc_r    <= '0;
          nb_r     <= '0;
        end else begin
          acc_r <= acc_new;
          nb_r  <= nb_r + 3'd1;
        end
      end
      if (cmd.push && out_free) begin
        acc_r    <= '0;
        nb_r     <= '0;
      end
    end
  end

  // run payload and output beat payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      copy_r  <= (d_mode == M_COPY);
      value_r <= d_value;
      dist_r  <= d_dist[HIST_AW-1:0];
      dok_r   <= d_dok;
      total_r <= total;
    end
    if (cmd.rd) ok_r <= dok_r && (dist_r != '0) && ({9'd0, dist_r} <= pos_r);
    if (cmd.latch) value_r <= ok_r ? rdata_r : 8'd0;
    if (cmd.wr) begin
      if (beat && out_free) begin
        opix_r  <= acc_new;
        ocnt_r  <= nb_r + 3'd1;
        olast_r <= last_byte;
        odone_r <= done_new;
      end else if (beat) begin
        pend_last_r <= last_byte;
        pend_done_r <= done_new;
      end
    end
    if (cmd.push && out_free) begin
      opix_r  <= acc_r;
      ocnt_r  <= nb_r;
      olast_r <= pend_last_r;
      odone_r <= pend_done_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_pixels = opix_r;
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;
  assign out_done   = odone_r;

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// tb_top: self-checking bench for the planar run-length image decoder
// drives code byte beats with random gaps and stalls, predicts decoded beats
// depends on prid_pkg and planar_rle_image_decoder
`default_nettype none
module tb_top;
  import prid_pkg::*;

  localparam int LIMIT = 2000000;
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;
  localparam logic [7:0] CODE_BACK_MIN = 8'h08;
  localparam logic [7:0] CODE_BACK_MAX = 8'h0D;

  // run kinds of the predictor
  localparam int MODE_NONE = 0;
  localparam int MODE_LIT  = 1;
  localparam int MODE_FILL = 2;
  localparam int MODE_COPY = 3;

  typedef struct packed {
    logic [31:0] pix;
    logic [2:0]  cnt;
    logic        last;
    logic        done;
  } pix_beat_t;

  // directed row: start flag, code byte, typed result (has_exp) or predictor
  typedef struct {
    logic       start;
    logic [7:0] code;
    logic       has_exp;
    pix_beat_t  exp_beat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [9:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;

  always #2 clk = ~clk;

  planar_rle_image_decoder i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  // decoder state mirror
  logic [7:0]  m_columns;
  logic [9:0]  m_rows;
  logic [7:0]  m_hist [HIST_DEPTH];
  int unsigned m_pos, m_col, m_plane;
  logic [1:0]  m_phase;
  logic [7:0]  m_cmd, m_len;

  pix_beat_t   pending_beats[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      cycles = 0;

  function automatic int unsigned eff_cols();
    return (m_columns > MAX_COLUMNS) ? MAX_COLUMNS : m_columns;
  endfunction

  function automatic logic [7:0] back_byte(longint back_dist);
    if (back_dist <= 0 || back_dist > m_pos || back_dist > HIST_DEPTH) return 8'h00;
    return m_hist[(m_pos - back_dist) % HIST_DEPTH];
  endfunction

  // decode one code byte, queue the beats it yields
  task automatic decode_code(input logic start, input logic [7:0] b);
    int unsigned c, total, len, nb;
    logic [31:0] acc;
    logic [7:0] val, v;
    longint back_dist, two_rows;
    int mode;
    len = 0; mode = MODE_NONE; nb = 0; acc = '0; val = '0; back_dist = 0;
    if (start) begin
      m_pos = 0; m_phase = PH_CMD; m_col = 0; m_plane = 0;
    end
    c = eff_cols();
    total = c * m_rows * 4;
    if (m_pos >= total) return;
    two_rows = longint'(c) * 8 - 1;
    if (m_phase == PH_LEN) begin
      m_len = b; len = b & LEN_MASK; m_phase = PH_CMD;
      if (m_cmd == CODE_FILL_EXPL) begin
        if (b[7]) begin
          mode = MODE_FILL; val = back_byte(two_rows);
        end else m_phase = PH_VAL;
      end else if (m_cmd == CODE_COPY_P2) begin
        mode = MODE_COPY; back_dist = longint'(c) * (longint'(m_plane) - 2);
      end else begin
        mode = MODE_COPY;
        back_dist = longint'(c) * (b[7] ? longint'(m_plane) - 1 : longint'(m_plane));
      end
    end else if (m_phase == PH_VAL) begin
      mode = MODE_FILL; val = b;
      len = (m_cmd == CODE_FILL_EXPL) ? (m_len & LEN_MASK) : (m_cmd & 8'h07);
      m_phase = PH_CMD;
    end else begin
      m_phase = PH_CMD;
      if (b >= CODE_LIT_MIN) begin
        mode = MODE_LIT; val = b; len = 1;
      end else if (b >= 8'h01 && b <= CODE_REP_MAX) begin
        m_cmd = b; m_phase = PH_VAL;
      end else if (b == CODE_FILL_EXPL || b == CODE_COPY_P2 || b == CODE_COPY_P01) begin
        m_cmd = b; m_phase = PH_LEN;
      end else begin
        mode = MODE_FILL; len = b - CODE_BACK_BIAS; val = back_byte(two_rows);
      end
    end
    if (mode == MODE_NONE || len == 0) return;
    if (len > total - m_pos) len = total - m_pos;
    for (int unsigned k = 0; k < len; k++) begin
      v = (mode == MODE_COPY) ? back_byte(back_dist) : val;
      m_hist[m_pos % HIST_DEPTH] = v;
      m_pos++; m_col++;
      if (m_col >= c) begin
        m_col = 0; m_plane = (m_plane + 1) & 3;
      end
      acc |= 32'(v) << (8 * nb);
      nb++;
      if (nb == 4 || k + 1 == len) begin
        pending_beats.push_back('{pix: acc, cnt: 3'(nb), last: (k + 1 == len),
                                  done: (m_pos == total)});
        acc = '0; nb = 0;
      end
    end
  endtask

  // output side: random stall and beat check
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    pix_beat_t got, want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{pix: out_tdata[31:0], cnt: out_tdata[34:32], last: out_tlast,
              done: out_tuser[0]};
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: expected no beat, got %h", $time, got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected pix %h cnt %0d last %b done %b, got %h %0d %b %b",
                   $time, want.pix, want.cnt, want.last, want.done,
                   got.pix, got.cnt, got.last, got.done);
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLUMNS) m_columns = val[7:0];
    else m_rows = val;
  endtask

  // send one beat; inputs change at the falling edge, valid stays up after
  // the beat until the next beat or an idle cycle replaces it
  task automatic send_code(input logic start, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= b; in_tuser <= start;
    decode_code(start, b);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // well-formed command with random content, sometimes noise
  task automatic send_random_cmd(input int unsigned max_len);
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1: send_code(1'b0, 8'($urandom_range(255, 16)));
      2: begin
        send_code(1'b0, 8'($urandom_range(7, 1)));
        send_code(1'b0, 8'($urandom));
      end
      3: begin
        send_code(1'b0, CODE_FILL_EXPL);
        send_code(1'b0, 8'($urandom_range(max_len)));
        send_code(1'b0, 8'($urandom));
      end
      4: begin
        send_code(1'b0, CODE_FILL_EXPL);
        send_code(1'b0, 8'h80 | 8'($urandom_range(max_len)));
      end
      5: send_code(1'b0, 8'($urandom_range(CODE_BACK_MAX, CODE_BACK_MIN)));
      6: begin
        send_code(1'b0, CODE_COPY_P2);
        send_code(1'b0, {1'($urandom), 7'($urandom_range(max_len))});
      end
      7: begin
        send_code(1'b0, CODE_COPY_P01);
        send_code(1'b0, {1'($urandom), 7'($urandom_range(max_len))});
      end
      8: send_code(1'($urandom_range(3) == 0), 8'($urandom));
      default: send_code(1'b1, 8'($urandom_range(255, 16)));
    endcase
  endtask

  dir_row_t dir_rows[$];

  initial begin
    m_columns = 80; m_rows = 400;
    foreach (m_hist[i]) m_hist[i] = 8'h00;
    m_pos = 0; m_phase = PH_CMD; m_cmd = 0; m_len = 0; m_col = 0; m_plane = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: columns 2, rows 2 -> 16-byte image
    write_reg(CFG_COLUMNS, 10'd2);
    write_reg(CFG_ROWS, 10'd2);
    dir_rows = '{
      '{1'b1, 8'h10, 1'b1, '{32'h10, 3'd1, 1'b1, 1'b0}},
      '{1'b0, 8'hFF, 1'b1, '{32'hFF, 3'd1, 1'b1, 1'b0}},
      '{1'b0, 8'h07, 1'b0, '0},
      '{1'b0, 8'hA5, 1'b0, '0},
      '{1'b0, CODE_FILL_EXPL, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, CODE_FILL_EXPL, 1'b0, '0},
      '{1'b0, 8'h81, 1'b0, '0},
      '{1'b0, CODE_BACK_MIN, 1'b0, '0},
      '{1'b0, CODE_COPY_P2, 1'b0, '0},
      '{1'b0, 8'h02, 1'b0, '0},
      '{1'b0, CODE_COPY_P01, 1'b0, '0},
      '{1'b0, 8'h83, 1'b0, '0},
      '{1'b0, CODE_BACK_MAX, 1'b0, '0},
      '{1'b0, 8'h55, 1'b0, '0},
      '{1'b1, CODE_COPY_P01, 1'b0, '0},
      '{1'b0, 8'h7F, 1'b0, '0},
      '{1'b1, 8'h7F, 1'b0, '0},
      '{1'b0, 8'hEE, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        send_code(dir_rows[i].start, dir_rows[i].code);
        void'(pending_beats.pop_back());
        pending_beats.push_back(dir_rows[i].exp_beat);
      end else send_code(dir_rows[i].start, dir_rows[i].code);
    end
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (ph)
        0: begin write_reg(CFG_COLUMNS, 10'd1);   write_reg(CFG_ROWS, 10'd1);    end
        1: begin write_reg(CFG_COLUMNS, 10'd128); write_reg(CFG_ROWS, 10'd1023); end
        2: begin write_reg(CFG_COLUMNS, 10'd3);   write_reg(CFG_ROWS, 10'd4);    end
        3: begin write_reg(CFG_COLUMNS, 10'd255); write_reg(CFG_ROWS, 10'd2);    end
        4: begin write_reg(CFG_COLUMNS, 10'd0);   write_reg(CFG_ROWS, 10'd5);    end
        5: begin write_reg(CFG_COLUMNS, 10'd8);   write_reg(CFG_ROWS, 10'd0);    end
        6: begin write_reg(CFG_COLUMNS, 10'd5);   write_reg(CFG_ROWS, 10'd3);    end
        default: begin write_reg(CFG_COLUMNS, 10'd16); write_reg(CFG_ROWS, 10'd8); end
      endcase
      send_code(1'b1, 8'($urandom_range(255, 16)));
      for (int n = 0; n < 18; n++) send_random_cmd((ph == 1) ? 127 : 24);
      drain();
    end

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
